// ===== rtl/aac_au_packetizer_top_defines.svh =====
// Assertion macros for the audio access unit packetizer.
`ifndef AAC_AU_PACKETIZER_TOP_DEFINES_SVH
`define AAC_AU_PACKETIZER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checks that a property holds at every clock edge outside of reset.
`define AAC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("packetizer assertion failed");
// Checks that a condition never occurs outside of reset.
`define AAC_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("packetizer forbidden condition seen");
`else
`define AAC_ASSERT(lbl, prop)
`define AAC_ASSERT_NEVER(lbl, expr)
`endif

`endif

// ===== rtl/aac_pkg.sv =====
// Shared types and constants of the audio access unit packetizer.
package aac_pkg;

  localparam int unsigned DataW     = 8;
  localparam int unsigned SizeW     = 13;
  localparam int unsigned CntW      = 11;
  localparam int unsigned CfgW      = 12;
  localparam int unsigned HdrBytes  = 4;

  localparam logic [DataW-1:0] HdrByte0 = 8'h00;
  localparam logic [DataW-1:0] HdrByte1 = 8'h10;

  // One classified input byte, queued between the front and back ends.
  typedef struct packed {
    logic [DataW-1:0] data;
    logic [SizeW-1:0] unit_size;
    logic             opens;
    logic             marker;
    logic             pkt_end;
  } entry_t;

endpackage

// ===== rtl/aac_front.sv =====
// Front end: accepts unit bytes, tracks unit and packet position, classifies each byte.
module aac_front import aac_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CfgW-1:0]  cfg_data_i,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [23:0]      s_axis_tdata,
  input  logic             full_i,
  output logic             push_o,
  output entry_t           entry_o
);

  localparam logic [CntW-1:0] PayloadReset = 11'd1496;
  localparam logic [CntW-1:0] PayloadMin   = 11'd1;
  localparam logic [CntW-1:0] PayloadMax   = 11'd2044;
  localparam logic [CfgW-1:0] PktMin       = 12'd5;
  localparam logic [CfgW-1:0] PktMax       = 12'd2048;

  logic [CntW-1:0]  payload_q;
  logic [SizeW-1:0] left_q, left_d;
  logic [CntW-1:0]  inpkt_q, inpkt_d;
  logic [SizeW-1:0] size_q, size_d;
  logic             final_q, final_d;

  logic [DataW-1:0] in_byte;
  logic [SizeW-1:0] in_size;
  logic             accept;
  logic             new_unit;
  logic [SizeW-1:0] left_cur;
  logic [CntW-1:0]  inpkt_cur;
  logic [CntW-1:0]  inpkt_inc;
  logic             opens;
  logic             pkt_end;
  logic [CfgW-1:0]  cfg_minus_hdr;

  assign in_byte       = s_axis_tdata[DataW-1:0];
  assign in_size       = s_axis_tdata[DataW+SizeW-1:DataW];
  assign s_axis_tready = !full_i;
  assign accept        = s_axis_tvalid && !full_i;
  assign cfg_ready_o   = 1'b1;
  assign cfg_minus_hdr = cfg_data_i - CfgW'(HdrBytes);

  always_comb begin
    new_unit  = (left_q == '0);
    left_cur  = left_q;
    size_d    = size_q;
    inpkt_cur = inpkt_q;
    if (new_unit) begin
      // A unit size of zero is treated as a one-byte unit.
      left_cur  = (in_size == '0) ? SizeW'(1) : in_size;
      size_d    = left_cur;
      inpkt_cur = '0;
    end
    opens   = (inpkt_cur == '0);
    final_d = opens ? (left_cur <= {2'b00, payload_q}) : final_q;
    left_d  = left_cur - SizeW'(1);
    inpkt_inc = inpkt_cur + CntW'(1);
    pkt_end = (left_d == '0) || (inpkt_inc >= payload_q);
    inpkt_d = pkt_end ? '0 : inpkt_inc;

    entry_o.data      = in_byte;
    entry_o.unit_size = size_d;
    entry_o.opens     = opens;
    entry_o.marker    = final_d;
    entry_o.pkt_end   = pkt_end;
  end

  assign push_o = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      payload_q <= PayloadReset;
      left_q    <= '0;
      inpkt_q   <= '0;
      size_q    <= '0;
      final_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_data_i < PktMin) begin
          payload_q <= PayloadMin;
        end else if (cfg_data_i > PktMax) begin
          payload_q <= PayloadMax;
        end else begin
          payload_q <= cfg_minus_hdr[CntW-1:0];
        end
      end
      if (accept) begin
        left_q  <= left_d;
        inpkt_q <= inpkt_d;
        size_q  <= size_d;
        final_q <= final_d;
      end
    end
  end

endmodule

// ===== rtl/aac_fifo.sv =====
// Short queue of classified bytes between the front and back ends.
module aac_fifo import aac_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t wdata_i,
  input  logic   pop_i,
  output entry_t rdata_o,
  output logic   full_o,
  output logic   empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + CntW'(1);
        2'b01:   cnt_q <= cnt_q - CntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== rtl/aac_back.sv =====
// Back end: emits each queued byte, preceded by the four header bytes when it opens a new packet.
module aac_back import aac_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       empty_i,
  input  entry_t     entry_i,
  output logic       pop_o,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,
  output logic       m_axis_tlast,
  output logic [1:0] m_axis_tuser
);

  localparam logic [2:0] PhasePayload = 3'(HdrBytes);

  entry_t     cur_q;
  logic       valid_q;
  logic [2:0] phase_q;
  logic       in_hdr;
  logic       take;
  logic       load;

  assign in_hdr = cur_q.opens && (phase_q != PhasePayload);
  assign take   = valid_q && m_axis_tready;
  assign load   = !valid_q || (take && !in_hdr);
  assign pop_o  = load && !empty_i;

  always_comb begin
    m_axis_tdata = cur_q.data;
    if (in_hdr) begin
      unique case (phase_q[1:0])
        2'd0:    m_axis_tdata = HdrByte0;
        2'd1:    m_axis_tdata = HdrByte1;
        2'd2:    m_axis_tdata = cur_q.unit_size[SizeW-1:5];
        default: m_axis_tdata = {cur_q.unit_size[4:0], 3'b000};
      endcase
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tlast  = !in_hdr && cur_q.pkt_end;
  assign m_axis_tuser  = {!in_hdr, cur_q.marker};

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= PhasePayload;
    end else begin
      if (load) begin
        valid_q <= !empty_i;
        if (!empty_i) begin
          phase_q <= entry_i.opens ? 3'd0 : PhasePayload;
        end
      end else if (take && in_hdr) begin
        phase_q <= phase_q + 3'd1;
      end
    end
  end

endmodule

// ===== rtl/aac_au_packetizer_top.sv =====
// Top level of the audio access unit packetizer.
// The slave stream takes one byte of an access unit per transaction: tdata[7:0] is
// the byte, tdata[20:8] the unit size, which is sampled on the first byte of a unit.
// The master stream gives one byte per transaction: tdata is the byte, tlast ends a
// packet, tuser[0] marks every byte of the unit's last packet and tuser[1] marks the
// last output byte caused by an input byte.
// Each packet opens with four header bytes (0x00, 0x10, then the 13-bit unit size and
// a zero index), so an input byte that opens a packet yields five output bytes and
// any other byte yields one. The cfg channel writes the maximum packet length; it is
// always ready and must only be written while the block holds no pending bytes.
// An input byte is registered in the queue, then in the back end, before it reaches
// the output. The output sustains one byte per cycle while the receiver is ready
// and bytes are queued. The input takes one byte per cycle while the queue has room;
// each packet opener holds the back end for its four header bytes, and the queue of
// FifoDepth classified bytes spreads the stalls this causes. A stalled receiver holds
// the current byte; the input keeps accepting until the queue is full. Reset clears
// all unit and packet tracking and sets the packet length to 1500 bytes.
`include "aac_au_packetizer_top_defines.svh"

module aac_au_packetizer_top import aac_pkg::*; #(
  parameter int unsigned FifoDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [11:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // data_byte [7:0], unit_size [20:8], zero [23:21]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // out_byte [7:0]
  output logic        m_axis_tlast,
  output logic [1:0]  m_axis_tuser    // unit_end_marker [0], run_last [1]
);

  entry_t push_entry;
  entry_t head_entry;
  logic   push;
  logic   pop;
  logic   full;
  logic   empty;
  logic   out_take;
  logic   out_hdr;
  logic   mid_pkt;
  logic   marker;

  aac_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_data_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .full_i  (full),
    .push_o  (push),
    .entry_o (push_entry)
  );

  aac_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .wdata_i (push_entry),
    .pop_i   (pop),
    .rdata_o (head_entry),
    .full_o  (full),
    .empty_o (empty)
  );

  aac_back u_back (
    .clk_i,
    .rst_ni,
    .empty_i (empty),
    .entry_i (head_entry),
    .pop_o   (pop),
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tlast,
    .m_axis_tuser
  );

  assign out_take = m_axis_tvalid && m_axis_tready;
  assign out_hdr  = m_axis_tvalid && !m_axis_tuser[1];
  assign mid_pkt  = out_take && !m_axis_tlast;
  assign marker   = m_axis_tuser[0];

  // Header bytes are never the last result of an input and never end a packet.
  `AAC_ASSERT_NEVER(a_hdr_no_last, out_hdr && m_axis_tlast)
  // Once a header byte is taken, the rest of that item follows without a gap.
  `AAC_ASSERT(a_hdr_continues, out_take && out_hdr |=> m_axis_tvalid)
  // The marker is constant within a packet across back-to-back transactions.
  `AAC_ASSERT(a_marker_stable, m_axis_tvalid && $past(mid_pkt) |-> marker == $past(marker))
  // The queue never refuses a push that the input side accepted.
  `AAC_ASSERT_NEVER(a_no_push_full, push && full)

endmodule
